FILE: src/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants of the sorted score table.
// Holds the fixed field widths, the result codes and the state encoding.
// ----------------------------------------------------------------------------
package sst_pkg;

    // Width of the total and streak fields.
    localparam int VAL_W  = 31;
    // Width of the reported rank.
    localparam int RANK_W = 7;

    typedef logic [RANK_W-1:0] t_rank;

    // Result codes.
    typedef enum logic [1:0] {
        OUT_UPDATED  = 2'd0,
        OUT_INSERTED = 2'd1,
        OUT_DROPPED  = 2'd2
    } t_outcome;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SEARCH = 8'b0000_0010,
        ST_MISS   = 8'b0000_0100,
        ST_UP_RD  = 8'b0000_1000,
        ST_UP_CMP = 8'b0001_0000,
        ST_DN_RD  = 8'b0010_0000,
        ST_DN_CMP = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } t_state;

endpackage

FILE: src/sst_ram.sv
// ----------------------------------------------------------------------------
// sst_ram: generic simple dual-port RAM.
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/sorted_score_table.sv
// From the input transfer to a valid result: a key search that reads one entry per cycle
// from the record RAM (skipped while the table is empty), then the record moves one
// position at a time, then a write (none for a dropped record).
// Throughput: one item at a time; the next transfer is taken once the sequencer is idle,
// while an earlier result may still wait in the output register.
// Reset: synchronous, active low; clears the fill count, the sequencer and the output
// valid. The record RAM is not cleared; only entries below the fill count are read.
// ----------------------------------------------------------------------------
// sorted_score_table: leaderboard kept in descending order of total and streak.
// Looks up a key, replaces or appends its record and moves it to its sorted place; drops when full.
// ----------------------------------------------------------------------------
module sorted_score_table #(
    parameter int ENTRIES  = 64,
    parameter int KEY_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Input channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [KEY_BITS-1:0]     i_user_key,
    input  logic [sst_pkg::VAL_W-1:0] i_total_seconds,
    input  logic [sst_pkg::VAL_W-1:0] i_streak_seconds,
    // Output channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [sst_pkg::RANK_W-1:0] o_placed_rank,
    output logic [1:0]              o_outcome
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = CNT_W + 1;
    localparam int SORT_W = 2 * sst_pkg::VAL_W;
    localparam int REC_W  = KEY_BITS + SORT_W;

    localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_TWO = IDX_W'(2);
    localparam logic [IDX_W:0]   RNK_ONE = (IDX_W + 1)'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);

    sst_pkg::t_state   r_state, n_state;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [SORT_W-1:0] r_sort, n_sort;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic [IDX_W-1:0]  r_cmp, n_cmp;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_moved, n_moved;
    logic              r_drop, n_drop;
    sst_pkg::t_outcome r_outcome, n_outcome;
    logic              r_out_valid, n_out_valid;
    sst_pkg::t_rank    r_rank, n_rank;
    sst_pkg::t_outcome r_out_code, n_out_code;

    logic              mem_wr_en;
    logic [IDX_W-1:0]  mem_wr_addr;
    logic [REC_W-1:0]  mem_wr_data;
    logic              mem_rd_en;
    logic [IDX_W-1:0]  mem_rd_addr;
    logic [REC_W-1:0]  mem_rd_data;

    logic [KEY_BITS-1:0] rd_key;
    logic [SORT_W-1:0] rd_sort;
    logic              rec_gt;
    logic              rec_lt;
    logic              in_xfer;
    logic [CMP_W-1:0]  pos_c;
    logic [CMP_W-1:0]  cnt_c;

    // Record store: key in the high bits, then total, then streak.
    sst_ram #(
        .WIDTH (REC_W),
        .DEPTH (ENTRIES)
    ) u_rec_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // Fields of the entry read last cycle and its order against the held record.
    assign rd_key  = mem_rd_data[REC_W-1 -: KEY_BITS];
    assign rd_sort = mem_rd_data[SORT_W-1:0];
    assign rec_gt  = r_sort > rd_sort;
    assign rec_lt  = rd_sort > r_sort;
    assign pos_c   = CMP_W'(r_pos);
    assign cnt_c   = CMP_W'(r_cnt);

    assign o_in_ready = (r_state == sst_pkg::ST_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;

    // Sequencer: search, then shift neighbors one slot per cycle, then place the record unless dropped.
    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_sort      = r_sort;
        n_pos       = r_pos;
        n_cmp       = r_cmp;
        n_cnt       = r_cnt;
        n_moved     = r_moved;
        n_drop      = r_drop;
        n_outcome   = r_outcome;
        n_out_valid = r_out_valid && !i_out_ready;
        n_rank      = r_rank;
        n_out_code  = r_out_code;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_pos;
        mem_wr_data = mem_rd_data;

        case (r_state)
            sst_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_key   = i_user_key;
                    n_sort  = {i_total_seconds, i_streak_seconds};
                    n_cmp   = '0;
                    n_moved = 1'b0;
                    n_drop  = 1'b0;
                    if (r_cnt == '0) begin
                        n_state = sst_pkg::ST_MISS;
                    end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                        n_state     = sst_pkg::ST_SEARCH;
                    end
                end
            end
            sst_pkg::ST_SEARCH: begin
                // Compare the entry that arrives, fetch the next one.
                if (rd_key == r_key) begin
                    n_pos     = r_cmp;
                    n_outcome = sst_pkg::OUT_UPDATED;
                    n_state   = sst_pkg::ST_UP_RD;
                end else if (CMP_W'(r_cmp) + CMP_W'(1) == cnt_c) begin
                    n_state = sst_pkg::ST_MISS;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = r_cmp + IDX_ONE;
                    n_cmp       = r_cmp + IDX_ONE;
                end
            end
            sst_pkg::ST_MISS: begin
                if (r_cnt == CNT_FULL) begin
                    n_drop    = 1'b1;
                    n_outcome = sst_pkg::OUT_DROPPED;
                    n_state   = sst_pkg::ST_FINISH;
                end else begin
                    n_pos     = IDX_W'(r_cnt);
                    n_cnt     = r_cnt + CNT_W'(1);
                    n_outcome = sst_pkg::OUT_INSERTED;
                    n_state   = sst_pkg::ST_UP_RD;
                end
            end
            sst_pkg::ST_UP_RD: begin
                if (r_pos == '0) begin
                    n_state = sst_pkg::ST_DN_RD;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = r_pos - IDX_ONE;
                    n_state     = sst_pkg::ST_UP_CMP;
                end
            end
            sst_pkg::ST_UP_CMP: begin
                // A strictly greater record passes its upper neighbor.
                if (rec_gt) begin
                    mem_wr_en = 1'b1;
                    n_pos     = r_pos - IDX_ONE;
                    n_moved   = 1'b1;
                    if (r_pos == IDX_ONE) begin
                        n_state = sst_pkg::ST_FINISH;
                    end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = r_pos - IDX_TWO;
                    end
                end else if (r_moved) begin
                    n_state = sst_pkg::ST_FINISH;
                end else begin
                    n_state = sst_pkg::ST_DN_RD;
                end
            end
            sst_pkg::ST_DN_RD: begin
                if (pos_c + CMP_W'(1) < cnt_c) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = r_pos + IDX_ONE;
                    n_state     = sst_pkg::ST_DN_CMP;
                end else begin
                    n_state = sst_pkg::ST_FINISH;
                end
            end
            sst_pkg::ST_DN_CMP: begin
                // A strictly greater lower neighbor moves up past the record.
                if (rec_lt) begin
                    mem_wr_en = 1'b1;
                    n_pos     = r_pos + IDX_ONE;
                    if (pos_c + CMP_W'(2) < cnt_c) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = r_pos + IDX_TWO;
                    end else begin
                        n_state = sst_pkg::ST_FINISH;
                    end
                end else begin
                    n_state = sst_pkg::ST_FINISH;
                end
            end
            sst_pkg::ST_FINISH: begin
                // Place the record; repeating the write while the output is full is harmless.
                if (!r_drop) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = {r_key, r_sort};
                end
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_rank      = r_drop ? '0
                                         : sst_pkg::t_rank'({1'b0, r_pos} + RNK_ONE);
                    n_out_code  = r_outcome;
                    n_state     = sst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sst_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sst_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_sort     <= n_sort;
        r_pos      <= n_pos;
        r_cmp      <= n_cmp;
        r_moved    <= n_moved;
        r_drop     <= n_drop;
        r_outcome  <= n_outcome;
        r_rank     <= n_rank;
        r_out_code <= n_out_code;
    end

    assign o_out_valid   = r_out_valid;
    assign o_placed_rank = r_rank;
    assign o_outcome     = r_out_code;

    // The fill count never exceeds the table size.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_FULL)
        else $error("fill count beyond table size");

    // The fill count only grows, one record at a time.
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_cnt != $past(r_cnt))) |-> (r_cnt == $past(r_cnt) + CNT_W'(1)))
        else $error("fill count changed by other than one");

    // Writes land only inside the filled part of the table.
    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wr_en |-> (CMP_W'(mem_wr_addr) < cnt_c))
        else $error("record write beyond fill count");

    // A dropped record reports rank zero.
    a_drop_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_outcome == sst_pkg::OUT_DROPPED)) |-> (o_placed_rank == '0))
        else $error("dropped record with nonzero rank");

endmodule

FILE: tb/tb_sorted_score_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_score_table: self-checking bench for the sorted score table.
// A queue of score updates feeds a valid/ready driver. A built-in leaderboard
// predicts the rank and outcome of every accepted transfer. A monitor compares
// each result, in order, with the oldest prediction. Random idling runs on
// both channels outside a calm window, and two long receiver hold-offs back the block up.
// ----------------------------------------------------------------------------
module tb_sorted_score_table;

    localparam int ENTRIES    = 64;
    localparam int KEY_BITS   = 32;
    localparam int VAL_W      = sst_pkg::VAL_W;
    localparam int RAND_ITEMS = 1000;
    localparam int POOL_SIZE  = 72;
    localparam int HOLD_LEN   = 400;
    localparam int STALL_MAX  = 5000;
    localparam int DRAIN_LEN  = 2 * ENTRIES + 16;
    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [VAL_W-1:0]    total;
        logic [VAL_W-1:0]    streak;
    } t_score_item;

    typedef struct packed {
        sst_pkg::t_rank    rank;
        sst_pkg::t_outcome outcome;
    } t_placement;

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_in_valid       = 1'b0;
    logic                o_in_ready;
    logic [KEY_BITS-1:0] i_user_key       = '0;
    logic [VAL_W-1:0]    i_total_seconds  = '0;
    logic [VAL_W-1:0]    i_streak_seconds = '0;
    logic                o_out_valid;
    logic                i_out_ready      = 1'b0;
    sst_pkg::t_rank      o_placed_rank;
    logic [1:0]          o_outcome;

    t_score_item         pending_scores[$];
    t_placement          expected_places[$];
    t_score_item         next_score;
    t_placement          got_place;

    // Predicted leaderboard contents, in rank order.
    logic [KEY_BITS-1:0] board_key[ENTRIES];
    logic [VAL_W-1:0]    board_total[ENTRIES];
    logic [VAL_W-1:0]    board_streak[ENTRIES];
    int                  board_fill = 0;

    logic [KEY_BITS-1:0] key_pool[POOL_SIZE];
    int                  fail_count   = 0;
    int                  result_count = 0;
    int                  cycle_count  = 0;
    int                  stall_count  = 0;
    int                  hold_left    = 0;
    bit                  held_first   = 1'b0;
    bit                  held_second  = 1'b0;
    bit                  calm;

    sorted_score_table #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_user_key       (i_user_key),
        .i_total_seconds  (i_total_seconds),
        .i_streak_seconds (i_streak_seconds),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_placed_rank    (o_placed_rank),
        .o_outcome        (o_outcome)
    );

    // Clock generation, 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // A window of cycles in which neither side idles.
    assign calm = (cycle_count >= 20000) && (cycle_count < 40000);

    // Sort key of a predicted record: total first, streak as tie-break.
    function automatic logic [2*VAL_W-1:0] rec_val(int p);
        return {board_total[p], board_streak[p]};
    endfunction

    function automatic void swap_records(int a, int b);
        logic [KEY_BITS-1:0] k;
        logic [VAL_W-1:0]    t;
        logic [VAL_W-1:0]    s;
        k = board_key[a];
        t = board_total[a];
        s = board_streak[a];
        board_key[a]    = board_key[b];
        board_total[a]  = board_total[b];
        board_streak[a] = board_streak[b];
        board_key[b]    = k;
        board_total[b]  = t;
        board_streak[b] = s;
    endfunction

    // Applies one update to the predicted board and returns where it landed.
    function automatic t_placement place_record(t_score_item it);
        t_placement res;
        int         pos;
        bit         hit;
        hit = 1'b0;
        pos = 0;
        for (int i = 0; i < board_fill; i++) begin
            if (!hit && board_key[i] == it.key) begin
                hit = 1'b1;
                pos = i;
            end
        end
        if (!hit && board_fill >= ENTRIES) begin
            res.rank    = '0;
            res.outcome = sst_pkg::OUT_DROPPED;
            return res;
        end
        if (!hit) begin
            pos = board_fill;
            board_key[pos] = it.key;
            board_fill++;
        end
        board_total[pos]  = it.total;
        board_streak[pos] = it.streak;
        // Only strictly greater or smaller neighbours are passed.
        while (pos > 0 && rec_val(pos) > rec_val(pos - 1)) begin
            swap_records(pos, pos - 1);
            pos--;
        end
        while (pos + 1 < board_fill && rec_val(pos + 1) > rec_val(pos)) begin
            swap_records(pos, pos + 1);
            pos++;
        end
        res.rank    = sst_pkg::t_rank'(pos + 1);
        res.outcome = hit ? sst_pkg::OUT_UPDATED : sst_pkg::OUT_INSERTED;
        return res;
    endfunction

    // Score values biased toward ties and the extremes.
    function automatic logic [VAL_W-1:0] rand_score();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return VAL_MAX;
            2, 3, 4: return VAL_W'($urandom_range(0, 3));
            5, 6:    return VAL_W'($urandom_range(0, 1000));
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic void add_score(logic [KEY_BITS-1:0] k, logic [VAL_W-1:0] t,
                                      logic [VAL_W-1:0] s);
        t_score_item it;
        it.key    = k;
        it.total  = t;
        it.streak = s;
        pending_scores.push_back(it);
    endfunction

    // Sender: offers the next queued update, idling at random between transfers.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pending_scores.size() > 0 && (calm || $urandom_range(0, 99) >= 20)) begin
                next_score = pending_scores.pop_front();
                i_in_valid       <= 1'b1;
                i_user_key       <= next_score.key;
                i_total_seconds  <= next_score.total;
                i_streak_seconds <= next_score.streak;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus two long hold-offs that fill the block up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!held_first && result_count >= 100) begin
            held_first  <= 1'b1;
            hold_left   <= HOLD_LEN;
            i_out_ready <= 1'b0;
        end else if (!held_second && result_count >= 600) begin
            held_second <= 1'b1;
            hold_left   <= HOLD_LEN;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(0, 99) >= 20);
        end
    end

    // Monitor: predicts on each input transfer, checks each output transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_places.push_back(place_record({i_user_key, i_total_seconds,
                                                        i_streak_seconds}));
            end
            if (o_out_valid && i_out_ready) begin
                result_count <= result_count + 1;
                if (expected_places.size() == 0) begin
                    $error("result transfer with no update pending: rank %0d, outcome %0d",
                           o_placed_rank, o_outcome);
                    fail_count++;
                end else begin
                    got_place = expected_places.pop_front();
                    if (o_placed_rank !== got_place.rank) begin
                        $error("placed_rank: expected %0d, actual %0d",
                               got_place.rank, o_placed_rank);
                        fail_count++;
                    end
                    if (o_outcome !== got_place.outcome) begin
                        $error("outcome: expected %0d, actual %0d",
                               got_place.outcome, o_outcome);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // Stimulus and end of run.
    initial begin
        // Directed part: extremes, ties, moves up and down, unchanged order.
        add_score(32'h0000_0000, VAL_MAX, VAL_MAX);
        add_score(32'hFFFF_FFFF, '0, '0);
        add_score(32'h0000_00A1, 31'd100, 31'd5);
        add_score(32'h0000_00B2, 31'd100, 31'd5);
        add_score(32'h0000_00C3, 31'd100, 31'd6);
        add_score(32'h0000_00B2, 31'd100, 31'd5);
        add_score(32'h0000_00A1, '0, '0);
        add_score(32'hFFFF_FFFF, VAL_MAX, VAL_MAX);
        add_score(32'h0000_0000, '0, '0);
        add_score(32'h5555_5555, 31'h2AAA_AAAA, 31'h5555_5555);
        add_score(32'hAAAA_AAAA, 31'h5555_5555, 31'h2AAA_AAAA);
        add_score(32'h0000_0000, '0, VAL_MAX);
        add_score(32'h0000_00C3, 31'd100, 31'd5);
        add_score(32'h0000_00C3, VAL_MAX, '0);
        add_score(32'hAAAA_AAAA, '0, '0);

        // Random part: a key pool a little larger than the table, so that it fills
        // up and later unknown keys get dropped, plus a share of fresh keys.
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h0000_00A1;
        key_pool[3] = 32'h0000_00B2;
        for (int i = 4; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                add_score($urandom, rand_score(), rand_score());
            end else begin
                add_score(key_pool[$urandom_range(0, POOL_SIZE - 1)], rand_score(),
                          rand_score());
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every update is taken and every result has come back.
        while (pending_scores.size() > 0 || i_in_valid || expected_places.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_LEN) @(posedge i_clk);

        if (fail_count == 0 && expected_places.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
